/* hdl/ets_pkg.sv */
// Package for the exhaustive tour search block.
// Holds action codes and field widths shared by the interfaces and modules.
`timescale 1ns / 1ps
`default_nettype none
package ets_pkg;
    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_SOLVE = 2'd2;
    localparam int COST_W = 20;
    localparam logic [COST_W-1:0] COST_SAT = '1;

    typedef struct packed {
        logic [1:0]  action;
        logic [3:0]  node_u;
        logic [3:0]  node_v;
        logic [15:0] weight;
        logic [3:0]  start_node;
    } t_in_item;

    typedef struct packed {
        logic              found;
        logic [COST_W-1:0] total_cost;
        logic [4:0]        position;
        logic [3:0]        route_node;
        logic              last;
    } t_out_item;
endpackage
`default_nettype wire

/* hdl/ets_if.sv */
// Valid/ready channel interfaces for the tour search block.
// Depends on ets_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface ets_in_if;
    import ets_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ets_out_if;
    import ets_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ets_cfg_if;
    logic       valid;
    logic       ready;
    logic [4:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hdl/exhaustive_tour_search.sv */
// Exhaustive tour search top level: weight memory, backtracking sequencer, route output.
// Depends on ets_pkg and ets_if.
// Edge write stores the weight in both directions. Clear zeroes every entry of the weight store.
// Solve: steps through candidates and depth changes with backtracking, checks each closed tour,
// then emits node_count+1 result items (one if no tour), held while the receiver stalls.
// Reset is synchronous and clears the weight store with the same sweep; no input meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module exhaustive_tour_search #(
    parameter int MAX_NODES   = 16,
    parameter int WEIGHT_BITS = 16
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    ets_in_if.sink   i_in,
    ets_cfg_if.sink  i_cfg,
    ets_out_if.source o_out
);
    import ets_pkg::*;
    localparam int NB = $clog2(MAX_NODES);
    localparam int AB = 2 * NB;
    localparam int CB = $clog2(MAX_NODES + 1);
    localparam int SW = WEIGHT_BITS + NB + 1;
    localparam int PB = $clog2(MAX_NODES + 2);

    localparam logic [3:0] S_INIT = 4'd0, S_IDLE = 4'd1, S_WR2 = 4'd2, S_CAND = 4'd3,
        S_CHK = 4'd4, S_CLOSE = 4'd5, S_CLCHK = 4'd6, S_OUT = 4'd7, S_NF = 4'd8;

    logic [3:0] r_st, n_st;
    logic [4:0] r_ncfg;
    logic [WEIGHT_BITS-1:0] r_mem [2**AB];
    logic [WEIGHT_BITS-1:0] r_rd;
    logic [AB-1:0] r_clr;
    logic [NB-1:0] r_path [MAX_NODES];
    logic [CB-1:0] r_nxt [MAX_NODES];
    logic [SW-1:0] r_pc [MAX_NODES];
    logic [NB-1:0] r_best [MAX_NODES];
    logic [SW-1:0] r_bcost;
    logic r_bval;
    logic [MAX_NODES-1:0] r_vis;
    logic [CB-1:0] r_depth, r_n, r_i;
    logic [NB-1:0] r_s, r_u, r_v;
    logic [WEIGHT_BITS-1:0] r_w;
    logic [PB-1:0] r_k;

    logic we;
    logic [AB-1:0] wa, ra;
    logic [CB-1:0] t;
    logic [NB-1:0] pos;
    logic [SW-1:0] sum;
    logic [CB-1:0] nsat;
    logic [CB-1:0] nx, inc;
    logic acc;
    logic wr_ok;

    assign acc = i_in.valid && i_in.ready;
    assign i_in.ready = (r_st == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign t = r_depth - CB'(1);
    assign pos = r_path[t[NB-1:0]];
    assign sum = r_pc[t[NB-1:0]] + SW'(r_rd);
    assign nsat = (int'(r_ncfg) > MAX_NODES) ? CB'(MAX_NODES) : CB'(r_ncfg);
    assign nx = r_nxt[t[NB-1:0]];
    assign inc = r_i + CB'(1);
    assign wr_ok = (int'(i_in.data.node_u) < MAX_NODES) && (int'(i_in.data.node_v) < MAX_NODES);

    always_comb begin
        we = 1'b0;
        wa = {r_u, r_v};
        ra = {pos, r_i[NB-1:0]};
        if (r_st == S_INIT) begin
            we = 1'b1;
            wa = r_clr;
        end else if (r_st == S_WR2) begin
            we = 1'b1;
            wa = {r_v, r_u};
        end else if (acc && i_in.data.action == ACT_WRITE && wr_ok) begin
            we = 1'b1;
            wa = {NB'(i_in.data.node_u), NB'(i_in.data.node_v)};
        end
        if (r_st == S_CAND) ra = {pos, nx[NB-1:0]};
        else if (r_st == S_CHK) ra = {pos, inc[NB-1:0]};
        else if (r_st == S_CLOSE) ra = {pos, r_s};
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[wa] <= (r_st == S_INIT) ? '0 :
                             (r_st == S_WR2) ? r_w : WEIGHT_BITS'(i_in.data.weight);
        r_rd <= r_mem[ra];
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_INIT: if (r_clr == '1) n_st = S_IDLE;
            S_IDLE: if (acc) begin
                unique case (i_in.data.action)
                    ACT_CLEAR: n_st = S_INIT;
                    ACT_WRITE: n_st = S_WR2;
                    ACT_SOLVE: n_st = (nsat >= CB'(2)
                                       && int'(i_in.data.start_node) < int'(nsat))
                                      ? S_CAND : S_NF;
                    default: n_st = S_IDLE;
                endcase
            end
            default: n_st = r_st;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_INIT;
            r_clr <= '0;
            r_ncfg <= 5'd16;
            r_k <= '0;
            r_bval <= 1'b0;
        end else begin
            if (i_cfg.valid) r_ncfg <= i_cfg.data;
            unique case (r_st)
                S_INIT: begin
                    r_clr <= r_clr + AB'(1);
                    if (r_clr == '1) r_st <= S_IDLE;
                end
                S_IDLE: begin
                    r_st <= n_st;
                    r_u <= NB'(i_in.data.node_u);
                    r_v <= NB'(i_in.data.node_v);
                    r_w <= WEIGHT_BITS'(i_in.data.weight);
                    r_s <= NB'(i_in.data.start_node);
                    r_n <= nsat;
                    r_depth <= CB'(1);
                    r_path[0] <= NB'(i_in.data.start_node);
                    r_nxt[0] <= '0;
                    r_pc[0] <= '0;
                    r_vis <= MAX_NODES'(1) << NB'(i_in.data.start_node);
                    r_bval <= 1'b0;
                    r_bcost <= '1;
                    r_i <= '0;
                    r_k <= '0;
                    if (n_st == S_INIT) r_clr <= '0;
                    if (n_st == S_WR2 && !wr_ok) r_st <= S_IDLE;
                end
                S_WR2: r_st <= S_IDLE;
                S_CAND: begin
                    if (r_depth == '0) begin
                        r_st <= r_bval ? S_OUT : S_NF;
                    end else if (r_depth == r_n) begin
                        r_st <= S_CLOSE;
                    end else begin
                        r_i <= nx;
                        r_st <= S_CHK;
                        if (nx >= r_n) begin
                            r_vis[pos] <= 1'b0;
                            r_depth <= t;
                            r_st <= S_CAND;
                        end
                    end
                end
                S_CHK: begin
                    // r_rd holds weight(pos, r_i)
                    if (r_vis[r_i[NB-1:0]] || r_rd == '0) begin
                        if (inc >= r_n) begin
                            r_vis[pos] <= 1'b0;
                            r_depth <= t;
                            r_st <= S_CAND;
                        end else begin
                            r_i <= inc;
                        end
                    end else begin
                        r_nxt[t[NB-1:0]] <= inc;
                        r_path[r_depth[NB-1:0]] <= r_i[NB-1:0];
                        r_nxt[r_depth[NB-1:0]] <= '0;
                        r_pc[r_depth[NB-1:0]] <= sum;
                        r_vis[r_i[NB-1:0]] <= 1'b1;
                        r_depth <= r_depth + CB'(1);
                        r_st <= S_CAND;
                    end
                end
                S_CLOSE: r_st <= S_CLCHK;
                S_CLCHK: begin
                    if (r_rd != '0 && (!r_bval || sum < r_bcost)) begin
                        r_bval <= 1'b1;
                        r_bcost <= sum;
                        for (int j = 0; j < MAX_NODES; j++) r_best[j] <= r_path[j];
                    end
                    r_vis[pos] <= 1'b0;
                    r_depth <= t;
                    r_st <= S_CAND;
                end
                S_OUT: if (o_out.ready) begin
                    r_k <= r_k + PB'(1);
                    if (PB'(r_n) == r_k) r_st <= S_IDLE;
                end
                S_NF: if (o_out.ready) r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end

    logic [NB-1:0] rn;
    always_comb begin
        rn = r_s;
        if (r_k < PB'(MAX_NODES) && PB'(r_n) != r_k) rn = r_best[r_k[NB-1:0]];
    end

    assign o_out.valid = (r_st == S_OUT) || (r_st == S_NF);
    always_comb begin
        o_out.data = '0;
        o_out.data.last = 1'b1;
        if (r_st == S_OUT) begin
            o_out.data.found = 1'b1;
            o_out.data.total_cost = (r_bcost > SW'(COST_SAT)) ? COST_SAT : COST_W'(r_bcost);
            o_out.data.position = 5'(r_k);
            o_out.data.route_node = 4'(rn);
            o_out.data.last = (PB'(r_n) == r_k);
        end
    end

    ast_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !o_out.valid) else $error("ready while emitting");
    ast_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_CHK) |-> (r_depth != '0 && r_depth < r_n)) else $error("bad depth");
    ast_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.data.last) |=> (r_st == S_IDLE))
        else $error("no return to idle");
endmodule
`default_nettype wire
